// ===== rtl/kbd_pkg.sv =====
package kbd_pkg;

   localparam int CHAR_DEPTH  = 256;
   localparam int EVENT_DEPTH = 256;
   localparam int CHAR_AW     = $clog2(CHAR_DEPTH);
   localparam int EVENT_AW    = $clog2(EVENT_DEPTH);

   localparam logic [15:0] EV_KEY     = 16'd1;
   localparam logic [15:0] CODE_F12    = 16'd88;
   localparam logic [15:0] CODE_LSHIFT = 16'd42;
   localparam logic [15:0] CODE_RSHIFT = 16'd54;
   localparam logic [15:0] CODE_LCTRL  = 16'd29;
   localparam logic [15:0] CODE_RCTRL  = 16'd97;
   localparam logic [15:0] CODE_LIMIT  = 16'd128;
   localparam logic [31:0] VAL_PRESS   = 32'd1;
   localparam logic [31:0] VAL_REPEAT  = 32'd2;
   localparam logic [7:0]  ESC_CHAR    = 8'h1b;

   typedef enum logic [1:0] {
      OP_KEY       = 2'd0,
      OP_POP_CHAR  = 2'd1,
      OP_POP_EVENT = 2'd2,
      OP_TAKE_F12  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        ev_push;
      logic [8:0]  ev_data;
      logic        ch_push;
      logic [7:0]  ch_data;
      logic        f12;
   } cmd_type;

   // unshifted keymap; letters shift by clearing bit 5
   function automatic logic [7:0] kbd_char(input logic [6:0] code, input logic shift);
      logic [7:0] lo;
      logic [7:0] hi;
      logic       letter;
      lo = 8'h00;
      hi = 8'h00;
      letter = 1'b0;
      unique case (code)
         7'd1:  begin lo = 8'h1b; hi = 8'h1b; end
         7'd2:  begin lo = 8'h31; hi = 8'h21; end
         7'd3:  begin lo = 8'h32; hi = 8'h40; end
         7'd4:  begin lo = 8'h33; hi = 8'h23; end
         7'd5:  begin lo = 8'h34; hi = 8'h24; end
         7'd6:  begin lo = 8'h35; hi = 8'h25; end
         7'd7:  begin lo = 8'h36; hi = 8'h5e; end
         7'd8:  begin lo = 8'h37; hi = 8'h26; end
         7'd9:  begin lo = 8'h38; hi = 8'h2a; end
         7'd10: begin lo = 8'h39; hi = 8'h28; end
         7'd11: begin lo = 8'h30; hi = 8'h29; end
         7'd12: begin lo = 8'h2d; hi = 8'h5f; end
         7'd13: begin lo = 8'h3d; hi = 8'h2b; end
         7'd14: begin lo = 8'h08; hi = 8'h08; end
         7'd15: begin lo = 8'h09; hi = 8'h09; end
         7'd16: begin lo = 8'h71; letter = 1'b1; end
         7'd17: begin lo = 8'h77; letter = 1'b1; end
         7'd18: begin lo = 8'h65; letter = 1'b1; end
         7'd19: begin lo = 8'h72; letter = 1'b1; end
         7'd20: begin lo = 8'h74; letter = 1'b1; end
         7'd21: begin lo = 8'h79; letter = 1'b1; end
         7'd22: begin lo = 8'h75; letter = 1'b1; end
         7'd23: begin lo = 8'h69; letter = 1'b1; end
         7'd24: begin lo = 8'h6f; letter = 1'b1; end
         7'd25: begin lo = 8'h70; letter = 1'b1; end
         7'd26: begin lo = 8'h5b; hi = 8'h7b; end
         7'd27: begin lo = 8'h5d; hi = 8'h7d; end
         7'd28: begin lo = 8'h0d; hi = 8'h0d; end
         7'd30: begin lo = 8'h61; letter = 1'b1; end
         7'd31: begin lo = 8'h73; letter = 1'b1; end
         7'd32: begin lo = 8'h64; letter = 1'b1; end
         7'd33: begin lo = 8'h66; letter = 1'b1; end
         7'd34: begin lo = 8'h67; letter = 1'b1; end
         7'd35: begin lo = 8'h68; letter = 1'b1; end
         7'd36: begin lo = 8'h6a; letter = 1'b1; end
         7'd37: begin lo = 8'h6b; letter = 1'b1; end
         7'd38: begin lo = 8'h6c; letter = 1'b1; end
         7'd39: begin lo = 8'h3b; hi = 8'h3a; end
         7'd40: begin lo = 8'h27; hi = 8'h22; end
         7'd41: begin lo = 8'h60; hi = 8'h7e; end
         7'd43: begin lo = 8'h5c; hi = 8'h7c; end
         7'd44: begin lo = 8'h7a; letter = 1'b1; end
         7'd45: begin lo = 8'h78; letter = 1'b1; end
         7'd46: begin lo = 8'h63; letter = 1'b1; end
         7'd47: begin lo = 8'h76; letter = 1'b1; end
         7'd48: begin lo = 8'h62; letter = 1'b1; end
         7'd49: begin lo = 8'h6e; letter = 1'b1; end
         7'd50: begin lo = 8'h6d; letter = 1'b1; end
         7'd51: begin lo = 8'h2c; hi = 8'h3c; end
         7'd52: begin lo = 8'h2e; hi = 8'h3e; end
         7'd53: begin lo = 8'h2f; hi = 8'h3f; end
         7'd55: begin lo = 8'h2a; hi = 8'h2a; end
         7'd57: begin lo = 8'h20; hi = 8'h20; end
         default: begin lo = 8'h00; hi = 8'h00; end
      endcase
      if (letter) begin
         hi = lo & 8'hdf;
      end
      return shift ? hi : lo;
   endfunction

endpackage

// ===== rtl/kbd_front.sv =====
module kbd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [15:0]          req_event_type,
   input  logic [15:0]          req_key_code,
   input  logic [31:0]          req_key_value,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output kbd_pkg::cmd_type     cmd
);
   import kbd_pkg::*;

   logic shift_ff, shift_in;
   logic ctrl_ff, ctrl_in;
   logic f12_ff, f12_in;
   logic accept;
   logic is_key;
   logic held;
   logic [7:0] map_char;
   logic [7:0] xl_char;
   cmd_type cmd_w;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;
   assign is_key    = (op_type'(req_type) == OP_KEY) && (req_event_type == EV_KEY);
   assign held      = (req_key_value != '0);
   assign map_char  = kbd_char(req_key_code[6:0], shift_ff);

   always_comb begin
      xl_char = map_char;
      if (req_key_code >= CODE_LIMIT) begin
         xl_char = '0;
      end else if (map_char != '0 && ctrl_ff) begin
         // letters become control codes, '[' becomes escape
         if ((map_char >= 8'h61 && map_char <= 8'h7a) ||
             (map_char >= 8'h41 && map_char <= 8'h5a)) begin
            xl_char = {3'b000, map_char[4:0]};
         end else if (map_char == 8'h5b) begin
            xl_char = ESC_CHAR;
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      f12_in   = f12_ff;
      cmd_w.op      = op_type'(req_type);
      cmd_w.ev_push = is_key;
      cmd_w.ev_data = {held, req_key_code[7:0]};
      cmd_w.ch_push = 1'b0;
      cmd_w.ch_data = xl_char;
      cmd_w.f12     = f12_ff;
      if (is_key) begin
         priority if (req_key_code == CODE_F12) begin
            if (req_key_value == VAL_PRESS) begin
               f12_in = 1'b1;
            end
         end else if (req_key_code == CODE_LSHIFT || req_key_code == CODE_RSHIFT) begin
            shift_in = held;
         end else if (req_key_code == CODE_LCTRL || req_key_code == CODE_RCTRL) begin
            ctrl_in = held;
         end else if (req_key_value == VAL_PRESS || req_key_value == VAL_REPEAT) begin
            cmd_w.ch_push = (xl_char != '0);
         end
      end else if (op_type'(req_type) == OP_TAKE_F12) begin
         f12_in = 1'b0;
      end
   end

   assign cmd = cmd_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         f12_ff   <= 1'b0;
      end else if (accept) begin
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         f12_ff   <= f12_in;
      end
   end

endmodule

// ===== rtl/kbd_queue.sv =====
module kbd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  kbd_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output kbd_pkg::cmd_type out_cmd
);
   import kbd_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/kbd_back.sv =====
module kbd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  kbd_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_read_ok,
   output logic [7:0]       rsp_ascii_byte,
   output logic [7:0]       rsp_raw_key,
   output logic             rsp_raw_pressed,
   output logic             rsp_f12_seen,
   output logic             rsp_ascii_waiting
);
   import kbd_pkg::*;

   logic [7:0] char_mem  [CHAR_DEPTH];
   logic [8:0] event_mem [EVENT_DEPTH];

   logic [CHAR_AW-1:0]  ch_head_ff, ch_head_in, ch_tail_ff, ch_tail_in;
   logic [CHAR_AW-1:0]  ch_head_nxt, ch_tail_nxt;
   logic [EVENT_AW-1:0] ev_head_ff, ev_head_in, ev_tail_ff, ev_tail_in;
   logic [EVENT_AW-1:0] ev_head_nxt, ev_tail_nxt;
   logic ch_empty, ch_full, ev_empty, ev_full;
   logic ch_wr, ev_wr, ch_rd, ev_rd;
   logic adv;

   logic       rsp_valid_ff;
   op_type     op_ff, op_in;
   logic       ok_ff, ok_in;
   logic       f12_ff, f12_in;
   logic       wait_ff, wait_in;
   logic [7:0] ch_rd_ff;
   logic [8:0] ev_rd_ff;

   assign adv       = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = !rsp_valid_ff || rsp_ready;

   assign ch_head_nxt = (ch_head_ff == CHAR_AW'(CHAR_DEPTH - 1)) ? '0 : ch_head_ff + 1'b1;
   assign ch_tail_nxt = (ch_tail_ff == CHAR_AW'(CHAR_DEPTH - 1)) ? '0 : ch_tail_ff + 1'b1;
   assign ev_head_nxt = (ev_head_ff == EVENT_AW'(EVENT_DEPTH - 1)) ? '0 : ev_head_ff + 1'b1;
   assign ev_tail_nxt = (ev_tail_ff == EVENT_AW'(EVENT_DEPTH - 1)) ? '0 : ev_tail_ff + 1'b1;
   assign ch_empty = (ch_head_ff == ch_tail_ff);
   assign ev_empty = (ev_head_ff == ev_tail_ff);
   // one slot stays free so full and empty differ
   assign ch_full  = (ch_head_nxt == ch_tail_ff);
   assign ev_full  = (ev_head_nxt == ev_tail_ff);

   always_comb begin
      ch_wr   = 1'b0;
      ev_wr   = 1'b0;
      ch_rd   = 1'b0;
      ev_rd   = 1'b0;
      ok_in   = 1'b0;
      f12_in  = 1'b0;
      op_in   = cmd.op;
      wait_in = !ch_empty;
      unique case (cmd.op)
         OP_KEY: begin
            ev_wr = cmd.ev_push && !ev_full;
            ch_wr = cmd.ch_push && !ch_full;
            wait_in = !ch_empty || ch_wr;
         end
         OP_POP_CHAR: begin
            ch_rd   = !ch_empty;
            ok_in   = !ch_empty;
            wait_in = !ch_empty && (ch_tail_nxt != ch_head_ff);
         end
         OP_POP_EVENT: begin
            ev_rd = !ev_empty;
            ok_in = !ev_empty;
         end
         OP_TAKE_F12: begin
            f12_in = cmd.f12;
            ok_in  = cmd.f12;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
      ch_head_in = (adv && ch_wr) ? ch_head_nxt : ch_head_ff;
      ev_head_in = (adv && ev_wr) ? ev_head_nxt : ev_head_ff;
      ch_tail_in = (adv && ch_rd) ? ch_tail_nxt : ch_tail_ff;
      ev_tail_in = (adv && ev_rd) ? ev_tail_nxt : ev_tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_head_ff   <= '0;
         ch_tail_ff   <= '0;
         ev_head_ff   <= '0;
         ev_tail_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ch_head_ff <= ch_head_in;
         ch_tail_ff <= ch_tail_in;
         ev_head_ff <= ev_head_in;
         ev_tail_ff <= ev_tail_in;
         if (adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff   <= op_in;
         ok_ff   <= ok_in;
         f12_ff  <= f12_in;
         wait_ff <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && ch_wr) begin
         char_mem[ch_head_ff] <= cmd.ch_data;
      end
      if (adv && ch_rd) begin
         ch_rd_ff <= char_mem[ch_tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && ev_wr) begin
         event_mem[ev_head_ff] <= cmd.ev_data;
      end
      if (adv && ev_rd) begin
         ev_rd_ff <= event_mem[ev_tail_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_ok       = ok_ff;
   assign rsp_ascii_byte    = (op_ff == OP_POP_CHAR && ok_ff) ? ch_rd_ff : 8'h00;
   assign rsp_raw_key       = (op_ff == OP_POP_EVENT && ok_ff) ? ev_rd_ff[7:0] : 8'h00;
   assign rsp_raw_pressed   = (op_ff == OP_POP_EVENT && ok_ff) ? ev_rd_ff[8] : 1'b0;
   assign rsp_f12_seen      = f12_ff;
   assign rsp_ascii_waiting = wait_ff;

endmodule

// ===== rtl/keyboard_event_to_ascii_queue.sv =====
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_ready | req_type, req_event_type, req_key_code, req_key_value
// rsp     | out       | rsp_valid/rsp_ready | rsp_read_ok .. rsp_ascii_waiting
//
// one word per cycle sustained while results are taken; an accepted request is registered in
// the command queue, then the back registers the result
// the front keeps shift, ctrl and the f12 flag; the back owns both fifo memories
// a stalled result holds the back; words then fill the two-deep command queue, and
// req_ready drops until the result is taken
// reset (synchronous) empties both fifos and clears modifiers; no clearing pass
module keyboard_event_to_ascii_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_event_type,
   input  logic [15:0] req_key_code,
   input  logic [31:0] req_key_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_read_ok,
   output logic [7:0]  rsp_ascii_byte,
   output logic [7:0]  rsp_raw_key,
   output logic        rsp_raw_pressed,
   output logic        rsp_f12_seen,
   output logic        rsp_ascii_waiting
);
   import kbd_pkg::*;

   cmd_type f_cmd, b_cmd;
   logic    f_valid, f_ready, b_valid, b_ready;

   kbd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_event_type (req_event_type),
      .req_key_code   (req_key_code),
      .req_key_value  (req_key_value),
      .cmd_valid      (f_valid),
      .cmd_ready      (f_ready),
      .cmd            (f_cmd)
   );

   kbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_cmd   (b_cmd)
   );

   kbd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (b_valid),
      .cmd_ready         (b_ready),
      .cmd               (b_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_ok       (rsp_read_ok),
      .rsp_ascii_byte    (rsp_ascii_byte),
      .rsp_raw_key       (rsp_raw_key),
      .rsp_raw_pressed   (rsp_raw_pressed),
      .rsp_f12_seen      (rsp_f12_seen),
      .rsp_ascii_waiting (rsp_ascii_waiting)
   );

endmodule

// ===== rtl/kbd_checker.sv =====
module kbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_read_ok,
   input logic [7:0] rsp_ascii_byte,
   input logic [7:0] rsp_raw_key,
   input logic       rsp_raw_pressed,
   input logic       rsp_f12_seen
);

   // a stalled word keeps its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_ok))
      else $error("stalled response word changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_ascii_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ascii_byte != 8'h00 |-> rsp_read_ok)
      else $error("character returned without read_ok");

   a_raw_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_raw_pressed || rsp_raw_key != 8'h00) |-> rsp_read_ok)
      else $error("raw event returned without read_ok");

   a_f12_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_f12_seen |-> rsp_read_ok && rsp_ascii_byte == 8'h00)
      else $error("f12 flag reported inconsistently");

endmodule

bind keyboard_event_to_ascii_queue kbd_checker u_kbd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_ok     (rsp_read_ok),
   .rsp_ascii_byte  (rsp_ascii_byte),
   .rsp_raw_key     (rsp_raw_key),
   .rsp_raw_pressed (rsp_raw_pressed),
   .rsp_f12_seen    (rsp_f12_seen)
);
